>>> src/tcw_pkg.sv
// shared types and constants for the text console writer
// no dependencies
package tcw_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] SPACE_CHAR   = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_WRITE,
    OP_READ,
    OP_CLEAR,
    OP_BAD
  } tcw_op_t;

  typedef struct packed {
    tcw_op_t    op;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
  } tcw_cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_DONE
  } tcw_state_t;

endpackage

>>> src/tcw_front.sv
// front end: accepts input transfers and classifies them into commands
// depends on tcw_pkg
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              q_full,
  input  logic              back_ready,
  output logic              push,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  logic [7:0] ch;
  logic [7:0] attr;
  logic [6:0] col;
  logic [4:0] row;
  logic       out_of_range;

  assign ch   = s_tdata[7:0];
  assign attr = s_tdata[15:8];
  assign col  = s_tdata[22:16];
  assign row  = s_tdata[27:23];

  assign out_of_range = (32'(col) >= COLUMNS) || (32'(row) >= ROWS);

  assign s_tready = !q_full && back_ready;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd.ch   = ch;
    cmd.attr = attr;
    cmd.col  = col;
    cmd.row  = row;
    case (s_tuser)
      KIND_PUT:   cmd.op = (ch == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
      KIND_WRITE: cmd.op = out_of_range ? OP_BAD : OP_WRITE;
      KIND_READ:  cmd.op = out_of_range ? OP_BAD : OP_READ;
      KIND_CLEAR: cmd.op = OP_CLEAR;
      default:    cmd.op = OP_BAD;
    endcase
  end

endmodule

>>> src/tcw_queue.sv
// short command queue between front end and back end
// depends on tcw_pkg
module tcw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcw_pkg::tcw_cmd_t push_cmd,
  output logic              full,
  output logic              valid,
  input  logic              pop,
  output tcw_pkg::tcw_cmd_t pop_cmd
);
  import tcw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  tcw_cmd_t        entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;

  assign full    = (count == NW'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/tcw_back.sv
// back end: screen memory, cursor, scroll and fill sequencer, result register
// depends on tcw_pkg
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  logic              q_valid,
  input  tcw_pkg::tcw_cmd_t q_cmd,
  output logic              q_pop,
  output logic              back_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int LW    = $clog2(COLUMNS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data;

  tcw_state_t    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [RW-1:0] cur_row, row_next;
  logic [LW-1:0] cur_col, col_next;
  logic          pend_scroll, pend_next;
  logic          mv_valid;
  logic [AW-1:0] mv_addr;
  logic [7:0]    text_color;

  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [15:0]   wd;
  logic          out_free;
  logic          load;
  logic [15:0]   ld_value;
  logic          ld_scroll, ld_bad;
  logic [CW-1:0] arow, lin;
  logic          wrap;

  logic [15:0]   out_value;
  logic [4:0]    out_row;
  logic [6:0]    out_col;
  logic          out_scroll, out_bad;

  assign out_free   = !m_tvalid || m_tready;
  assign back_ready = (state != S_INIT);
  assign m_tdata    = {2'b00, out_bad, out_scroll, out_col, out_row, out_value};

  assign arow = (q_cmd.op == OP_PUT) ? CW'(cur_row) : CW'(q_cmd.row);
  assign lin  = arow * CW'(COLUMNS)
              + ((q_cmd.op == OP_PUT) ? CW'(cur_col) : CW'(q_cmd.col));
  assign wrap = (q_cmd.op == OP_NEWLINE) || (cur_col == LW'(COLUMNS - 1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    row_next   = cur_row;
    col_next   = cur_col;
    pend_next  = pend_scroll;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    re         = 1'b0;
    ra         = '0;
    q_pop      = 1'b0;
    load       = 1'b0;
    ld_value   = '0;
    ld_scroll  = 1'b0;
    ld_bad     = 1'b0;
    case (state)
      S_INIT: begin
        we = 1'b1;
        wa = cnt[AW-1:0];
        wd = {RESET_COLOR, SPACE_CHAR};
        if (cnt == CW'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_PUT, OP_NEWLINE: begin
              if (q_cmd.op == OP_PUT) begin
                we = 1'b1;
                wa = lin[AW-1:0];
                wd = {text_color, q_cmd.ch};
              end
              if (wrap) begin
                col_next = '0;
                if (cur_row == RW'(ROWS - 1)) begin
                  cnt_next   = CW'(COLUMNS);
                  pend_next  = 1'b1;
                  state_next = S_SCROLL;
                end else begin
                  row_next = cur_row + 1'b1;
                  load     = 1'b1;
                end
              end else begin
                col_next = cur_col + 1'b1;
                load     = 1'b1;
              end
            end
            OP_WRITE: begin
              we   = 1'b1;
              wa   = lin[AW-1:0];
              wd   = {q_cmd.attr, q_cmd.ch};
              load = 1'b1;
            end
            OP_READ: begin
              re         = 1'b1;
              ra         = lin[AW-1:0];
              state_next = S_READ;
            end
            OP_CLEAR: begin
              cnt_next   = '0;
              row_next   = '0;
              col_next   = '0;
              pend_next  = 1'b0;
              state_next = S_FILL;
            end
            default: begin
              load   = 1'b1;
              ld_bad = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load       = 1'b1;
          ld_value   = rd_data;
          state_next = S_IDLE;
        end
      end
      S_SCROLL: begin
        if (cnt != CW'(CELLS)) begin
          re       = 1'b1;
          ra       = cnt[AW-1:0];
          cnt_next = cnt + 1'b1;
        end else begin
          cnt_next   = CW'((ROWS - 1) * COLUMNS);
          state_next = S_FILL;
        end
        if (mv_valid) begin
          we = 1'b1;
          wa = mv_addr;
          wd = rd_data;
        end
      end
      S_FILL: begin
        we = 1'b1;
        wa = cnt[AW-1:0];
        wd = {text_color, SPACE_CHAR};
        if (cnt == CW'(CELLS - 1)) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          ld_scroll  = pend_scroll;
          pend_next  = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    mv_addr <= AW'(cnt - CW'(COLUMNS));
    if (load) begin
      out_value  <= ld_value;
      out_row    <= 5'(row_next);
      out_col    <= 7'(col_next);
      out_scroll <= ld_scroll;
      out_bad    <= ld_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cnt         <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      pend_scroll <= 1'b0;
      mv_valid    <= 1'b0;
      text_color  <= RESET_COLOR;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      cur_row     <= row_next;
      cur_col     <= col_next;
      pend_scroll <= pend_next;
      mv_valid    <= (state == S_SCROLL) && (cnt != CW'(CELLS));
      if (cfg_valid) begin
        text_color <= cfg_data;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> src/text_console_writer.sv
// Text console writer with a ROWS x COLUMNS screen of 16-bit cells (color byte above
// character byte) and a cursor. After reset the screen is cleared to grey spaces one
// cell per cycle while s_tready stays low; color writes are taken at any time. Put
// character, newline, position write and bad positions load the result register
// directly; a read first passes the registered read port of the screen memory. Clears
// and scrolls are paced by the single write port of the screen memory, which moves or
// fills one cell per cycle. A two-entry command queue lets new items be taken while a
// result waits in the output register.
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code, cell_color, pos_col, pos_row
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_value, cursor_row_out, cursor_col_out, scrolled,
                                 // bad_position
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // text_color
);
  import tcw_pkg::*;

  tcw_cmd_t push_cmd;
  tcw_cmd_t pop_cmd;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  logic     back_ready;

  assign cfg_ready = 1'b1;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_full     (q_full),
    .back_ready (back_ready),
    .push       (push),
    .cmd        (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (pop),
    .pop_cmd  (pop_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (pop),
    .back_ready (back_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

>>> src/tcw_checker.sv
// port-level checks on the text console writer, with its bind statement
// depends on tcw_pkg and text_console_writer
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input taken during clearing pass");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[29] |-> m_tdata[15:0] == 16'd0 && !m_tdata[28])
    else $error("bad position with data or scroll");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> m_tdata[20:16] == 5'(ROWS - 1) && m_tdata[27:21] == 7'd0)
    else $error("scroll left cursor off last row start");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[20:16]) < ROWS || ROWS > 32)
    else $error("cursor row out of range");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/tb_text_console_writer.sv
// testbench for text_console_writer: drives stream transfers and color writes, updates a shadow
// copy of the screen and cursor for each accepted transfer and checks every returned report
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLS = DEFAULT_COLUMNS;
  localparam int LINES = DEFAULT_ROWS;
  localparam int CELLS = COLS * LINES;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int DIRECTED_COUNT = 21;

  typedef struct packed {
    logic [15:0] value;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
    logic        bad;
  } console_report_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      ch;
    logic [7:0]      attr;
    logic [6:0]      col;
    logic [4:0]      row;
    logic            typed;
    console_report_t want;
  } directed_row_t;

  // typed rows carry their report, the others go through the shadow console
  localparam directed_row_t DIRECTED [DIRECTED_COUNT] = '{
    '{KIND_READ,  8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_READ,  8'h00, 8'h00, 7'd79,  5'd24, 1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_READ,  8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0, 1'b1}},
    '{KIND_READ,  8'h00, 8'h00, 7'd80,  5'd0,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0, 1'b1}},
    '{KIND_WRITE, 8'hAA, 8'h55, 7'd0,   5'd25, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0, 1'b1}},
    '{KIND_WRITE, 8'hFF, 8'hFF, 7'd79,  5'd24, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_READ,  8'h00, 8'h00, 7'd79,  5'd24, 1'b1, '{16'hFFFF, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_WRITE, 8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_READ,  8'hFF, 8'hFF, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_PUT,   8'h41, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0, 1'b0}},
    '{KIND_PUT,   8'hFF, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd0, 7'd2, 1'b0, 1'b0}},
    '{KIND_PUT,   8'h00, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd0, 7'd3, 1'b0, 1'b0}},
    '{KIND_READ,  8'h00, 8'h00, 7'd1,   5'd0,  1'b1, '{16'h07FF, 5'd0, 7'd3, 1'b0, 1'b0}},
    '{KIND_PUT,   8'h0A, 8'h00, 7'd0,   5'd0,  1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0, 1'b0}},
    '{KIND_READ,  8'h00, 8'h00, 7'd3,   5'd0,  1'b1, '{16'h0720, 5'd1, 7'd0, 1'b0, 1'b0}},
    '{KIND_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_READ,  8'h00, 8'h00, 7'd1,   5'd0,  1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_WRITE, 8'h0A, 8'h3C, 7'd40,  5'd12, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_READ,  8'h00, 8'h00, 7'd40,  5'd12, 1'b1, '{16'h3C0A, 5'd0, 7'd0, 1'b0, 1'b0}},
    '{KIND_PUT,   8'h7F, 8'h12, 7'd99,  5'd30, 1'b0, '0},
    '{KIND_READ,  8'h00, 8'h00, 7'd0,   5'd0,  1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // char_code, cell_color, pos_col, pos_row
  logic [1:0]  s_tuser = '0;  // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // cell_value, cursor_row_out, cursor_col_out, scrolled,
                              // bad_position
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  logic [15:0]     shadow_screen [CELLS];
  int              cur_row;
  int              cur_col;
  logic [7:0]      shadow_color;
  console_report_t due_reports [$];
  int              errors = 0;
  int              items_sent = 0;
  int              cycles = 0;
  int              hold_left = 0;
  bit              hold_request = 1'b0;
  bit              idling_on = 1'b1;

  text_console_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic console_report_t console_apply(logic [1:0] kind, logic [7:0] ch,
                                                    logic [7:0] attr, logic [6:0] col,
                                                    logic [4:0] row);
    console_report_t rep;
    rep = '0;
    case (kind)
      KIND_PUT: begin
        if (ch != NEWLINE_CHAR) shadow_screen[cur_row * COLS + cur_col] = {shadow_color, ch};
        cur_col++;
        if (ch == NEWLINE_CHAR || cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= LINES) begin
            cur_row = LINES - 1;
            for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) begin
              shadow_screen[i] = {shadow_color, SPACE_CHAR};
            end
            rep.scrolled = 1'b1;
          end
        end
      end
      KIND_WRITE, KIND_READ: begin
        if (col >= COLS || row >= LINES) begin
          rep.bad = 1'b1;
        end else if (kind == KIND_WRITE) begin
          shadow_screen[row * COLS + col] = {attr, ch};
        end else begin
          rep.value = shadow_screen[row * COLS + col];
        end
      end
      default: begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = {shadow_color, SPACE_CHAR};
        cur_row = 0;
        cur_col = 0;
      end
    endcase
    rep.row = cur_row[4:0];
    rep.col = cur_col[6:0];
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 200) $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  function automatic void take_report(logic [31:0] data);
    console_report_t want;
    if (due_reports.size() == 0) begin
      errors++;
      if (errors <= 200) $display("%0t: report %h with none expected", $time, data);
      return;
    end
    want = due_reports.pop_front();
    check_field("cell_value", want.value, data[15:0]);
    check_field("cursor_row_out", want.row, data[20:16]);
    check_field("cursor_col_out", want.col, data[27:21]);
    check_field("scrolled", want.scrolled, data[28]);
    check_field("bad_position", want.bad, data[29]);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) take_report(m_tdata);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idling_on || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] ch, input logic [7:0] attr,
                           input logic [6:0] col, input logic [4:0] row, input logic typed,
                           input console_report_t want);
    int gap;
    console_report_t predicted;
    gap = 0;
    if (idling_on) while ($urandom_range(0, 99) < 38) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'b0, row, col, attr, ch};
    do @(posedge clk); while (!s_tready);
    predicted = console_apply(kind, ch, attr, col, row);
    due_reports.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic send_cell_op(input logic [1:0] kind);
    logic [6:0] col;
    logic [4:0] row;
    col = ($urandom_range(0, 99) < 15) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(0, COLS - 1));
    if ($urandom_range(0, 99) < 15) row = 5'($urandom_range(0, 31));
    else if ($urandom_range(0, 99) < 30) row = 5'(LINES - 1);
    else row = 5'($urandom_range(0, LINES - 1));
    send_item(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), col, row, 1'b0,
              '0);
  endtask

  task automatic write_color(input logic [7:0] value);
    s_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_color = value;
  endtask

  initial begin
    int line_len;
    int phase_end;
    int pick;
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {RESET_COLOR, SPACE_CHAR};
    cur_row = 0;
    cur_col = 0;
    shadow_color = RESET_COLOR;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // screen is cleared after reset before input opens
    do @(posedge clk); while (!s_tready);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_item(DIRECTED[i].kind, DIRECTED[i].ch, DIRECTED[i].attr, DIRECTED[i].col,
                DIRECTED[i].row, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) write_color(8'hFF);
      else if (p == 1) write_color(8'h00);
      else write_color(8'($urandom_range(0, 255)));
      idling_on = (p != 2);
      if (p == 4) hold_request = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      // text lines with cell reads and writes mixed in
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 2) begin
          send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)), 1'b0, '0);
        end
        line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 15);
        for (int j = 0; j < line_len; j++) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            send_item(KIND_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)), 1'b0, '0);
          end else if (pick < 85) begin
            send_cell_op(KIND_WRITE);
          end else begin
            send_cell_op(KIND_READ);
          end
        end
        if ($urandom_range(0, 9) != 0) begin
          send_item(KIND_PUT, NEWLINE_CHAR, 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)), 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
